// File: sv/gcm_pkg.sv
// Shared constants, types and AES/GCM helper functions for the GCM encryption engine.
// Used by gcm_keyexp, gcm_aes_core and aes_gcm_encrypt.
package gcm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumRk    = 15;
  localparam logic [3:0]  LastRnd  = 4'd14;
  localparam logic [4:0]  LastKeyEntry = 5'd29;

  localparam logic [CfgIdxW-1:0] REG_KEY0   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IV_HI  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IV_LO  = 3'd5;

  localparam logic [4:0]  FullBytes = 5'd16;
  localparam logic [31:0] CtrFirst  = 32'd2;
  localparam logic [31:0] CtrJ0     = 32'd1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_KEXP   = 10'b0000000010,
    S_HGEN   = 10'b0000000100,
    S_MGEN   = 10'b0000001000,
    S_DISP   = 10'b0000010000,
    S_CTR    = 10'b0000100000,
    S_CTOUT  = 10'b0001000000,
    S_GH     = 10'b0010000000,
    S_GHLEN  = 10'b0100000000,
    S_TAGOUT = 10'b1000000000
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns; AddRoundKey is done by the caller
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   a [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [7:0]   all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) a[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[i+4*c] = a[i+4*((c+i)&3)];
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = last ? t[i] : m[i];
    return r;
  endfunction

  // keep the leading n bytes of a block, n already clamped to 0..16
  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    return r;
  endfunction

endpackage

// File: sv/gcm_keyexp.sv
// AES-256 key expansion, one 64-bit round-key half per cycle, and round-key store.
// Depends on gcm_pkg.
module gcm_keyexp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  output logic         done,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key
);

  logic [63:0] rk_hi [gcm_pkg::NumRk];
  logic [63:0] rk_lo [gcm_pkg::NumRk];
  logic [63:0] win_r [4];
  logic [63:0] win_nxt [4];
  logic [4:0]  k_r, k_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] t;
  logic [31:0] new_hi, new_lo;
  logic [63:0] entry;
  logic [2:0]  rc_idx;
  logic [7:0]  rcon;

  always_comb begin
    rc_idx = k_r[4:2];
    rcon   = 8'h01 << (rc_idx - 3'd1);
    unique case (k_r[1:0])
      2'd0:    t = gcm_pkg::sub_word({win_r[3][23:0], win_r[3][31:24]}) ^ {rcon, 24'h0};
      2'd2:    t = gcm_pkg::sub_word(win_r[3][31:0]);
      default: t = win_r[3][31:0];
    endcase
    new_hi = win_r[0][63:32] ^ t;
    new_lo = win_r[0][31:0] ^ new_hi;
    if (k_r < 5'd4) begin
      unique case (k_r[1:0])
        2'd0:    entry = key[255:192];
        2'd1:    entry = key[191:128];
        2'd2:    entry = key[127:64];
        default: entry = key[63:0];
      endcase
    end else begin
      entry = {new_hi, new_lo};
    end
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = win_r[3];
    win_nxt[3] = entry;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      k_nxt    = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      k_nxt = k_r + 5'd1;
      if (k_r == gcm_pkg::LastKeyEntry) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r <= k_nxt;
    if (busy_r) begin
      for (int i = 0; i < 4; i++) win_r[i] <= win_nxt[i];
      if (k_r[0]) rk_lo[k_r[4:1]] <= entry;
      else        rk_hi[k_r[4:1]] <= entry;
    end
  end

  assign done   = done_r;
  assign rd_key = {rk_hi[rd_idx], rk_lo[rd_idx]};

endmodule

// File: sv/gcm_aes_core.sv
// Round-iterative AES-256 encryption: one round per cycle through a shared round unit.
// Depends on gcm_pkg; reads round keys from gcm_keyexp.
module gcm_aes_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] blk,
  output logic [3:0]   rk_idx,
  input  logic [127:0] rk,
  output logic         done,
  output logic [127:0] result
);

  logic [127:0] st_r, st_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  assign rk_idx = start ? 4'd0 : rnd_r;

  always_comb begin
    st_nxt   = st_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      st_nxt   = blk ^ rk;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt  = gcm_pkg::aes_round(st_r, rnd_r == gcm_pkg::LastRnd) ^ rk;
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == gcm_pkg::LastRnd) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    st_r  <= st_nxt;
    rnd_r <= rnd_nxt;
  end

  assign done   = done_r;
  assign result = st_r;

endmodule

// File: sv/gcm_ghash.sv
// GF(2^128) multiplier for GHASH, eight bits of the operand per cycle.
// Depends on nothing but its ports.
module gcm_ghash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] y,
  input  logic [127:0] h,
  output logic         done,
  output logic [127:0] z
);

  logic [127:0] y_r, y_nxt, z_r, z_nxt, v_r, v_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  always_comb begin
    y_nxt    = y_r;
    z_nxt    = z_r;
    v_nxt    = v_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      y_nxt    = y;
      z_nxt    = '0;
      v_nxt    = h;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // most significant bit first, GCM reflected order
      for (int i = 0; i < 8; i++) begin
        if (y_nxt[127]) z_nxt = z_nxt ^ v_nxt;
        v_nxt = {1'b0, v_nxt[127:1]} ^ (v_nxt[0] ? {8'he1, 120'h0} : 128'h0);
        y_nxt = {y_nxt[126:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    v_r   <= v_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

// File: sv/aes_gcm_encrypt.sv
// AES-256-GCM encryption engine: sequencer, configuration registers and output register.
// Depends on gcm_pkg, gcm_keyexp, gcm_aes_core and gcm_ghash.
//
// Usage: write the four key words and the IV through cfg_we/cfg_index/cfg_wdata
// while the engine is idle. Feed 16-byte items on the in_ channel (valid/stall);
// AAD items are only hashed, plaintext items give one ciphertext item on the out_
// channel. An item with end_of_message set is followed by the tag (out_is_tag).
// The engine takes one item at a time; in_stall stays high while it works.
// The first item of a message first runs key expansion and two AES passes for H
// and E(K,J0), one round per cycle. Per item: AAD is hashed by GHASH, 8 bits per
// cycle; plaintext runs the AES round loop then GHASH; the final item adds a GHASH
// pass for the length block and then gives the tag.
// One output register parts the channels: when out_stall holds a result the next
// result waits in its state, and the engine still accepts a new item when idle.
// Reset (rst_n low, synchronous) returns the engine to idle with no message open
// and clears the configuration registers.
module aes_gcm_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_is_aad,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic [4:0]  out_bytes,
  output logic        out_is_tag,
  output logic        out_last_result
);

  gcm_pkg::state_t state_r, state_nxt;

  logic [63:0]  key_r [4];
  logic [63:0]  iv_hi_r;
  logic [31:0]  iv_lo_r;

  logic [127:0] blk_r, blk_nxt;
  logic [4:0]   v_r, v_nxt;
  logic         aad_r, aad_nxt, eom_r, eom_nxt;
  logic [4:0]   in_v;

  logic [127:0] h_r, h_nxt, mask_r, mask_nxt, acc_r, acc_nxt, ct_r, ct_nxt;
  logic [31:0]  ctr_r, ctr_nxt;
  logic [63:0]  alen_r, alen_nxt, tlen_r, tlen_nxt;
  logic         started_r, started_nxt;

  logic         ov_r, ov_nxt;
  logic [127:0] od_r, od_nxt;
  logic [4:0]   ob_r, ob_nxt;
  logic         otag_r, otag_nxt, olast_r, olast_nxt;
  logic         out_free;

  logic         kx_start, kx_done;
  logic [3:0]   rk_idx;
  logic [127:0] rk;
  logic         aes_start, aes_done;
  logic [127:0] aes_blk, aes_out;
  logic         gh_start, gh_done;
  logic [127:0] gh_y, gh_z;
  logic [63:0]  vbits;

  gcm_keyexp u_kx (
    .clk(clk), .rst_n(rst_n), .start(kx_start),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .done(kx_done), .rd_idx(rk_idx), .rd_key(rk)
  );

  gcm_aes_core u_aes (
    .clk(clk), .rst_n(rst_n), .start(aes_start), .blk(aes_blk),
    .rk_idx(rk_idx), .rk(rk), .done(aes_done), .result(aes_out)
  );

  gcm_ghash u_gh (
    .clk(clk), .rst_n(rst_n), .start(gh_start), .y(gh_y), .h(h_r),
    .done(gh_done), .z(gh_z)
  );

  assign in_stall = (state_r != gcm_pkg::S_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign in_v     = in_valid_bytes[4] ? gcm_pkg::FullBytes : in_valid_bytes;
  assign vbits    = {56'h0, v_r, 3'b000};

  always_comb begin
    state_nxt   = state_r;
    blk_nxt     = blk_r;
    v_nxt       = v_r;
    aad_nxt     = aad_r;
    eom_nxt     = eom_r;
    h_nxt       = h_r;
    mask_nxt    = mask_r;
    acc_nxt     = acc_r;
    ct_nxt      = ct_r;
    ctr_nxt     = ctr_r;
    alen_nxt    = alen_r;
    tlen_nxt    = tlen_r;
    started_nxt = started_r;
    ov_nxt      = ov_r && out_stall;
    od_nxt      = od_r;
    ob_nxt      = ob_r;
    otag_nxt    = otag_r;
    olast_nxt   = olast_r;
    kx_start    = 1'b0;
    aes_start   = 1'b0;
    aes_blk     = '0;
    gh_start    = 1'b0;
    gh_y        = acc_r ^ {alen_r, tlen_r};

    unique case (state_r)
      gcm_pkg::S_IDLE: begin
        if (in_valid) begin
          blk_nxt = {in_block_high, in_block_low} & gcm_pkg::lead_mask(in_v);
          v_nxt   = in_v;
          aad_nxt = in_is_aad;
          eom_nxt = in_end_of_message;
          if (started_r) begin
            state_nxt = gcm_pkg::S_DISP;
          end else begin
            kx_start  = 1'b1;
            state_nxt = gcm_pkg::S_KEXP;
          end
        end
      end
      gcm_pkg::S_KEXP: begin
        if (kx_done) begin
          aes_start = 1'b1;
          state_nxt = gcm_pkg::S_HGEN;
        end
      end
      gcm_pkg::S_HGEN: begin
        if (aes_done) begin
          h_nxt     = aes_out;
          aes_blk   = {iv_hi_r, iv_lo_r, gcm_pkg::CtrJ0};
          aes_start = 1'b1;
          state_nxt = gcm_pkg::S_MGEN;
        end
      end
      gcm_pkg::S_MGEN: begin
        if (aes_done) begin
          mask_nxt    = aes_out;
          acc_nxt     = '0;
          ctr_nxt     = gcm_pkg::CtrFirst;
          alen_nxt    = '0;
          tlen_nxt    = '0;
          started_nxt = 1'b1;
          state_nxt   = gcm_pkg::S_DISP;
        end
      end
      gcm_pkg::S_DISP: begin
        if (v_r != 5'd0) begin
          if (aad_r) begin
            gh_y      = acc_r ^ blk_r;
            gh_start  = 1'b1;
            alen_nxt  = alen_r + vbits;
            state_nxt = gcm_pkg::S_GH;
          end else begin
            aes_blk   = {iv_hi_r, iv_lo_r, ctr_r};
            aes_start = 1'b1;
            state_nxt = gcm_pkg::S_CTR;
          end
        end else if (eom_r) begin
          gh_start  = 1'b1;
          state_nxt = gcm_pkg::S_GHLEN;
        end else begin
          state_nxt = gcm_pkg::S_IDLE;
        end
      end
      gcm_pkg::S_CTR: begin
        if (aes_done) begin
          ct_nxt    = (blk_r ^ aes_out) & gcm_pkg::lead_mask(v_r);
          ctr_nxt   = ctr_r + 32'd1;
          state_nxt = gcm_pkg::S_CTOUT;
        end
      end
      gcm_pkg::S_CTOUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = ct_r;
          ob_nxt    = v_r;
          otag_nxt  = 1'b0;
          olast_nxt = !eom_r;
          gh_y      = acc_r ^ ct_r;
          gh_start  = 1'b1;
          tlen_nxt  = tlen_r + vbits;
          state_nxt = gcm_pkg::S_GH;
        end
      end
      gcm_pkg::S_GH: begin
        if (gh_done) begin
          acc_nxt = gh_z;
          if (eom_r) begin
            // fold the length block straight away
            gh_y      = gh_z ^ {alen_r, tlen_r};
            gh_start  = 1'b1;
            state_nxt = gcm_pkg::S_GHLEN;
          end else begin
            state_nxt = gcm_pkg::S_IDLE;
          end
        end
      end
      gcm_pkg::S_GHLEN: begin
        if (gh_done) begin
          acc_nxt   = gh_z;
          state_nxt = gcm_pkg::S_TAGOUT;
        end
      end
      gcm_pkg::S_TAGOUT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          od_nxt      = acc_r ^ mask_r;
          ob_nxt      = gcm_pkg::FullBytes;
          otag_nxt    = 1'b1;
          olast_nxt   = 1'b1;
          started_nxt = 1'b0;
          state_nxt   = gcm_pkg::S_IDLE;
        end
      end
      default: state_nxt = gcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gcm_pkg::S_IDLE;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv_hi_r   <= '0;
      iv_lo_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gcm_pkg::REG_KEY0:  key_r[0] <= cfg_wdata;
          gcm_pkg::REG_KEY1:  key_r[1] <= cfg_wdata;
          gcm_pkg::REG_KEY2:  key_r[2] <= cfg_wdata;
          gcm_pkg::REG_KEY3:  key_r[3] <= cfg_wdata;
          gcm_pkg::REG_IV_HI: iv_hi_r  <= cfg_wdata;
          gcm_pkg::REG_IV_LO: iv_lo_r  <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
    blk_r   <= blk_nxt;
    v_r     <= v_nxt;
    aad_r   <= aad_nxt;
    eom_r   <= eom_nxt;
    h_r     <= h_nxt;
    mask_r  <= mask_nxt;
    acc_r   <= acc_nxt;
    ct_r    <= ct_nxt;
    ctr_r   <= ctr_nxt;
    alen_r  <= alen_nxt;
    tlen_r  <= tlen_nxt;
    od_r    <= od_nxt;
    ob_r    <= ob_nxt;
    otag_r  <= otag_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_high        = od_r[127:64];
  assign out_low         = od_r[63:0];
  assign out_bytes       = ob_r;
  assign out_is_tag      = otag_r;
  assign out_last_result = olast_r;

`ifndef SYNTH
  a_tag_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_tag |-> out_bytes == gcm_pkg::FullBytes && out_last_result)
    else $error("tag item not full or not last");

  a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(aes_done && gh_done))
    else $error("AES and GHASH finished together");

  a_new_msg_kexp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !started_r |=> state_r == gcm_pkg::S_KEXP)
    else $error("message start did not run key expansion");

  a_tag_closes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gcm_pkg::S_TAGOUT && out_free |=> !started_r)
    else $error("message still open after tag");
`endif

endmodule
